FILE: rtl/universal_machine_core_assert.svh
// Assertion macros for the universal machine core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef UNIVERSAL_MACHINE_CORE_ASSERT_SVH
`define UNIVERSAL_MACHINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("umc assertion failed");
`define UMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("umc assertion failed");
`else
`define UMC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/umc_pkg.sv
// Shared types and codes of the universal machine core.
// Used by the register file, the arithmetic unit and the top level of the core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package umc_pkg;

	typedef struct packed {
		logic        func;
		logic [31:0] load_word;
		logic [7:0]  in_char;
	} in_item_t;

	typedef struct packed {
		logic [3:0] status;
		logic       out_valid;
		logic [7:0] out_char;
		logic       input_used;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_CMOV     = 4'd0,
		OP_INDEX    = 4'd1,
		OP_AMEND    = 4'd2,
		OP_ADD      = 4'd3,
		OP_MUL      = 4'd4,
		OP_DIV      = 4'd5,
		OP_NAND     = 4'd6,
		OP_HALT     = 4'd7,
		OP_ALLOC    = 4'd8,
		OP_ABANDON  = 4'd9,
		OP_OUTPUT   = 4'd10,
		OP_INPUT    = 4'd11,
		OP_LOADPROG = 4'd12,
		OP_ORTHO    = 4'd13
	} opcode_t;

	typedef enum logic [3:0] {
		ST_RUNNING      = 4'd0,
		ST_HALTED       = 4'd1,
		ST_NO_PROGRAM   = 4'd2,
		ST_PC_RANGE     = 4'd3,
		ST_BAD_OPCODE   = 4'd4,
		ST_BAD_ID       = 4'd5,
		ST_INACTIVE     = 4'd6,
		ST_INDEX_RANGE  = 4'd7,
		ST_DIV_ZERO     = 4'd8,
		ST_NO_RESOURCES = 4'd9,
		ST_TOO_LONG     = 4'd10
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BEGIN,
		S_FETCH,
		S_RC,
		S_RA,
		S_EX,
		S_ALU,
		S_META,
		S_MEMRD,
		S_SCAN,
		S_SCANCHK,
		S_FILL,
		S_CPRD,
		S_CPWR
	} state_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_MUL,
		ALU_DIV,
		ALU_NAND
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic        we;
		logic [2:0]  addr;
		logic [31:0] data;
	} rf_wr_t;

	// Number of quotient bits the serial divider produces
	localparam logic [5:0] DIV_STEPS = 6'd32;

endpackage
`default_nettype wire

FILE: rtl/umc_mem.sv
// Single-port synchronous memory with registered read data.
// Generic; used for the array words and the slot table of the core.
`timescale 1ns / 1ps
`default_nettype none
module umc_mem #(
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [2**ADDR_W];
	logic [WIDTH-1:0] rdata_q;

	// write on request, read old contents every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/umc_regfile.sv
// Eight-entry general register file, one registered read port, one write port.
// Depends on umc_pkg; unwritten entries read as zero after reset.
`timescale 1ns / 1ps
`default_nettype none
module umc_regfile import umc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [2:0]  raddr,
	input  wire rf_wr_t      wr,
	output logic      [31:0] rdata
);

	logic [31:0] regs_q [8];
	logic [7:0]  valid_q;
	logic [31:0] rdata_q;

	// track which entries hold a written value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// store and read back
	always_ff @(posedge clk) begin
		if (wr.we) begin
			regs_q[wr.addr] <= wr.data;
		end
		rdata_q <= valid_q[raddr] ? regs_q[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/umc_alu.sv
// Shared arithmetic unit: add, multiply and nand answered in the cycle after the request, serial divide.
// Depends on umc_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none
module umc_alu import umc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire alu_req_t    req,
	input  wire logic [31:0] opa,
	input  wire logic [31:0] opb,
	output alu_rsp_t         rsp
);

	logic        done_q;
	logic        div_busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] res_q;
	logic [31:0] quot_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] rem_sh;
	logic        ge;
	logic [31:0] rem_nx;
	logic [32:0] rem_diff;

	// one restoring divide step
	always_comb begin
		rem_sh   = {rem_q, quot_q[31]};
		ge       = rem_sh >= {1'b0, dvs_q};
		rem_diff = rem_sh - {1'b0, dvs_q};
		rem_nx   = ge ? rem_diff[31:0] : rem_sh[31:0];
	end

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			div_busy_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.op == ALU_DIV) begin
					div_busy_q <= 1'b1;
					cnt_q      <= DIV_STEPS;
				end else begin
					done_q <= 1'b1;
				end
			end else if (div_busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					div_busy_q <= 1'b0;
					done_q     <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				ALU_ADD:  res_q <= opa + opb;
				ALU_MUL:  res_q <= opa * opb;
				ALU_NAND: res_q <= ~(opa & opb);
				ALU_DIV: begin
					quot_q <= opa;
					rem_q  <= '0;
					dvs_q  <= opb;
				end
				default: res_q <= '0;
			endcase
		end else if (div_busy_q) begin
			quot_q <= {quot_q[30:0], ge};
			rem_q  <= rem_nx;
			if (cnt_q == 6'd1) begin
				res_q <= {quot_q[30:0], ge};
			end
		end
	end

	assign rsp = '{done: done_q, res: res_q};

endmodule
`default_nettype wire

FILE: rtl/universal_machine_core.sv
// Top level of the universal machine core: sequencer, state and memories.
// Depends on umc_pkg, umc_mem, umc_regfile, umc_alu and the assertion header.
//
// Use: drive item and raise start while busy is low; the item transfers at
// that clock edge and busy rises. A func 0 item appends load_word to the
// program array; a func 1 item fetches and executes one instruction.
// Every item yields exactly one result: done is high for one cycle with
// result valid in that cycle. The receiver cannot stall; it must take it.
// A load or a stopped core ends in S_BEGIN; an instruction then passes
// S_FETCH, S_RC, S_RA and S_EX, where moves, immediates, input, output
// and jumps within the program end. Add, multiply, nand and divide wait
// in S_ALU for the shared unit (divide: one quotient bit per cycle); array
// reads and writes go through S_META, reads then through S_MEMRD. Alloc
// scans the slot table in S_SCAN and S_SCANCHK, then writes one zero word
// per cycle in S_FILL; a program copy alternates S_CPRD and S_CPWR, one
// read and one write per word on the single memory port.
// busy falls as done rises, so the next item can transfer at the edge that
// ends the done cycle.
// The output_enable register is written over the cfg channel (always ready);
// reset sets it to 1. Reset clears registers, program counter and program
// length, sets the slot count to 1; the core starts running with no program.
`timescale 1ns / 1ps
`default_nettype none
module universal_machine_core import umc_pkg::*; #(
	parameter int ARRAY_SLOTS = 64,
	parameter int ARRAY_WORDS = 1024
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t item,
	input  wire logic     cfg_valid,
	output logic          cfg_ready,
	input  wire logic     cfg_data,
	output logic          done,
	output out_item_t     result
);

	localparam int SW = $clog2(ARRAY_SLOTS);
	localparam int IW = $clog2(ARRAY_WORDS);
	localparam int LW = $clog2(ARRAY_WORDS + 1);
	localparam int CW = $clog2(ARRAY_SLOTS + 1);
	localparam int AW = SW + IW;

	state_t         state_q, state_d;
	status_t        stop_q;
	logic           oe_q;
	logic           done_q;
	out_item_t      result_q;
	in_item_t       item_q;
	logic [LW-1:0]  pc_q, pc_d;
	logic [LW-1:0]  len0_q, len0_d;
	logic [CW-1:0]  created_q, created_d;
	logic [CW-1:0]  scan_q, scan_d;
	logic [LW-1:0]  cnt_q, cnt_d;
	logic [31:0]    instr_q, instr_d;
	logic [31:0]    rb_q, rb_d;
	logic [31:0]    rc_q, rc_d;
	logic [SW-1:0]  acc_id_q, acc_id_d;
	logic [31:0]    acc_idx_q, acc_idx_d;
	logic [SW-1:0]  slot_q, slot_d;
	logic [LW-1:0]  size_q, size_d;

	opcode_t        op;
	logic [2:0]     fa, fb, fc;
	logic           meta_act;
	logic [LW-1:0]  meta_len;

	logic [2:0]     rf_raddr;
	logic [31:0]    rf_rdata;
	rf_wr_t         rf_wr;
	logic           mem_we;
	logic [AW-1:0]  mem_addr;
	logic [31:0]    mem_wdata;
	logic [31:0]    mem_rdata;
	logic           tab_we;
	logic [SW-1:0]  tab_addr;
	logic [LW:0]    tab_wdata;
	logic [LW:0]    tab_rdata;
	alu_req_t       alu_req;
	alu_rsp_t       alu_rsp;

	logic           fin;
	status_t        fin_status;
	logic           fin_ov;
	logic [7:0]     fin_oc;
	logic           fin_iu;

	umc_regfile u_regfile (
		.clk   (clk),
		.arst_n(arst_n),
		.raddr (rf_raddr),
		.wr    (rf_wr),
		.rdata (rf_rdata)
	);

	umc_mem #(.WIDTH(32), .ADDR_W(AW)) u_words (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// slot table entry: {active, length}
	umc_mem #(.WIDTH(LW + 1), .ADDR_W(SW)) u_slots (
		.clk  (clk),
		.we   (tab_we),
		.addr (tab_addr),
		.wdata(tab_wdata),
		.rdata(tab_rdata)
	);

	umc_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.opa   (rb_q),
		.opb   (rc_q),
		.rsp   (alu_rsp)
	);

	// decode fields
	assign op = opcode_t'(instr_q[31:28]);
	assign fa = instr_q[8:6];
	assign fb = instr_q[5:3];
	assign fc = instr_q[2:0];

	// slot zero lives outside the table
	assign meta_act = (acc_id_q == '0) ? 1'b1 : tab_rdata[LW];
	assign meta_len = (acc_id_q == '0) ? len0_q : tab_rdata[LW-1:0];

	// sequencer: next state and datapath controls
	always_comb begin
		state_d    = state_q;
		pc_d       = pc_q;
		len0_d     = len0_q;
		created_d  = created_q;
		scan_d     = scan_q;
		cnt_d      = cnt_q;
		instr_d    = instr_q;
		rb_d       = rb_q;
		rc_d       = rc_q;
		acc_id_d   = acc_id_q;
		acc_idx_d  = acc_idx_q;
		slot_d     = slot_q;
		size_d     = size_q;
		rf_raddr   = fb;
		rf_wr      = '0;
		mem_we     = 1'b0;
		mem_addr   = '0;
		mem_wdata  = '0;
		tab_we     = 1'b0;
		tab_addr   = acc_id_q;
		tab_wdata  = '0;
		alu_req    = '0;
		fin        = 1'b0;
		fin_status = stop_q;
		fin_ov     = 1'b0;
		fin_oc     = '0;
		fin_iu     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_BEGIN;
				end
			end
			S_BEGIN: begin
				if (stop_q != ST_RUNNING) begin
					fin = 1'b1;
				end else if (!item_q.func) begin
					fin = 1'b1;
					if (len0_q == LW'(ARRAY_WORDS)) begin
						fin_status = ST_TOO_LONG;
					end else begin
						mem_we    = 1'b1;
						mem_addr  = {{SW{1'b0}}, len0_q[IW-1:0]};
						mem_wdata = item_q.load_word;
						len0_d    = len0_q + 1'b1;
					end
				end else if (len0_q == '0) begin
					fin        = 1'b1;
					fin_status = ST_NO_PROGRAM;
				end else if (pc_q >= len0_q) begin
					fin        = 1'b1;
					fin_status = ST_PC_RANGE;
				end else begin
					mem_addr = {{SW{1'b0}}, pc_q[IW-1:0]};
					pc_d     = pc_q + 1'b1;
					state_d  = S_FETCH;
				end
			end
			S_FETCH: begin
				instr_d  = mem_rdata;
				rf_raddr = mem_rdata[5:3];
				state_d  = S_RC;
			end
			S_RC: begin
				rf_raddr = fc;
				rb_d     = rf_rdata;
				state_d  = S_RA;
			end
			S_RA: begin
				rf_raddr = fa;
				rc_d     = rf_rdata;
				state_d  = S_EX;
			end
			S_EX: begin
				case (op)
					OP_CMOV: begin
						if (rc_q != '0) begin
							rf_wr = '{we: 1'b1, addr: fa, data: rb_q};
						end
						fin = 1'b1;
					end
					OP_INDEX: begin
						if (rb_q >= 32'(created_q)) begin
							fin        = 1'b1;
							fin_status = ST_BAD_ID;
						end else begin
							acc_id_d  = rb_q[SW-1:0];
							acc_idx_d = rc_q;
							tab_addr  = rb_q[SW-1:0];
							state_d   = S_META;
						end
					end
					OP_AMEND: begin
						if (rf_rdata >= 32'(created_q)) begin
							fin        = 1'b1;
							fin_status = ST_BAD_ID;
						end else begin
							acc_id_d  = rf_rdata[SW-1:0];
							acc_idx_d = rb_q;
							tab_addr  = rf_rdata[SW-1:0];
							state_d   = S_META;
						end
					end
					OP_ADD: begin
						alu_req = '{start: 1'b1, op: ALU_ADD};
						state_d = S_ALU;
					end
					OP_MUL: begin
						alu_req = '{start: 1'b1, op: ALU_MUL};
						state_d = S_ALU;
					end
					OP_NAND: begin
						alu_req = '{start: 1'b1, op: ALU_NAND};
						state_d = S_ALU;
					end
					OP_DIV: begin
						if (rc_q == '0) begin
							fin        = 1'b1;
							fin_status = ST_DIV_ZERO;
						end else begin
							alu_req = '{start: 1'b1, op: ALU_DIV};
							state_d = S_ALU;
						end
					end
					OP_HALT: begin
						fin        = 1'b1;
						fin_status = ST_HALTED;
					end
					OP_ALLOC: begin
						if (rc_q > 32'(ARRAY_WORDS)) begin
							fin        = 1'b1;
							fin_status = ST_NO_RESOURCES;
						end else begin
							size_d  = rc_q[LW-1:0];
							scan_d  = CW'(1);
							state_d = S_SCAN;
						end
					end
					OP_ABANDON: begin
						fin = 1'b1;
						if (rc_q == '0) begin
							fin_status = ST_BAD_ID;
						end else if (rc_q < 32'(created_q)) begin
							tab_we    = 1'b1;
							tab_addr  = rc_q[SW-1:0];
							tab_wdata = '0;
						end
					end
					OP_OUTPUT: begin
						fin = 1'b1;
						if (oe_q) begin
							fin_ov = 1'b1;
							fin_oc = rc_q[7:0];
						end
					end
					OP_INPUT: begin
						rf_wr  = '{we: 1'b1, addr: fc, data: {24'b0, item_q.in_char}};
						fin_iu = 1'b1;
						fin    = 1'b1;
					end
					OP_LOADPROG: begin
						if (rb_q == '0) begin
							fin = 1'b1;
							if (rc_q >= 32'(len0_q)) begin
								fin_status = ST_PC_RANGE;
							end else begin
								pc_d = rc_q[LW-1:0];
							end
						end else if (rb_q >= 32'(created_q)) begin
							fin        = 1'b1;
							fin_status = ST_INACTIVE;
						end else begin
							acc_id_d  = rb_q[SW-1:0];
							acc_idx_d = rc_q;
							tab_addr  = rb_q[SW-1:0];
							state_d   = S_META;
						end
					end
					OP_ORTHO: begin
						rf_wr = '{we: 1'b1, addr: instr_q[27:25],
							data: {7'b0, instr_q[24:0]}};
						fin   = 1'b1;
					end
					default: begin
						fin        = 1'b1;
						fin_status = ST_BAD_OPCODE;
					end
				endcase
			end
			S_META: begin
				if (!meta_act) begin
					fin        = 1'b1;
					fin_status = ST_INACTIVE;
				end else if (acc_idx_q >= 32'(meta_len)) begin
					fin        = 1'b1;
					fin_status = ST_INDEX_RANGE;
				end else begin
					case (op)
						OP_INDEX: begin
							mem_addr = {acc_id_q, acc_idx_q[IW-1:0]};
							state_d  = S_MEMRD;
						end
						OP_AMEND: begin
							mem_we    = 1'b1;
							mem_addr  = {acc_id_q, acc_idx_q[IW-1:0]};
							mem_wdata = rc_q;
							fin       = 1'b1;
						end
						default: begin
							len0_d  = meta_len;
							pc_d    = acc_idx_q[LW-1:0];
							size_d  = meta_len;
							cnt_d   = '0;
							state_d = S_CPRD;
						end
					endcase
				end
			end
			S_MEMRD: begin
				rf_wr = '{we: 1'b1, addr: fa, data: mem_rdata};
				fin   = 1'b1;
			end
			S_ALU: begin
				if (alu_rsp.done) begin
					rf_wr = '{we: 1'b1, addr: fa, data: alu_rsp.res};
					fin   = 1'b1;
				end
			end
			S_SCAN: begin
				if (scan_q < created_q) begin
					tab_addr = scan_q[SW-1:0];
					state_d  = S_SCANCHK;
				end else if (created_q == CW'(ARRAY_SLOTS)) begin
					fin        = 1'b1;
					fin_status = ST_NO_RESOURCES;
				end else begin
					slot_d    = created_q[SW-1:0];
					created_d = created_q + 1'b1;
					tab_we    = 1'b1;
					tab_addr  = created_q[SW-1:0];
					tab_wdata = {1'b1, size_q};
					cnt_d     = '0;
					state_d   = S_FILL;
				end
			end
			S_SCANCHK: begin
				if (!tab_rdata[LW]) begin
					slot_d    = scan_q[SW-1:0];
					tab_we    = 1'b1;
					tab_addr  = scan_q[SW-1:0];
					tab_wdata = {1'b1, size_q};
					cnt_d     = '0;
					state_d   = S_FILL;
				end else begin
					scan_d  = scan_q + 1'b1;
					state_d = S_SCAN;
				end
			end
			S_FILL: begin
				if (cnt_q < size_q) begin
					mem_we    = 1'b1;
					mem_addr  = {slot_q, cnt_q[IW-1:0]};
					mem_wdata = '0;
					cnt_d     = cnt_q + 1'b1;
				end else begin
					rf_wr = '{we: 1'b1, addr: fb, data: 32'(slot_q)};
					fin   = 1'b1;
				end
			end
			S_CPRD: begin
				if (cnt_q < size_q) begin
					mem_addr = {acc_id_q, cnt_q[IW-1:0]};
					state_d  = S_CPWR;
				end else begin
					fin = 1'b1;
				end
			end
			S_CPWR: begin
				mem_we    = 1'b1;
				mem_addr  = {{SW{1'b0}}, cnt_q[IW-1:0]};
				mem_wdata = mem_rdata;
				cnt_d     = cnt_q + 1'b1;
				state_d   = S_CPRD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			stop_q    <= ST_RUNNING;
			oe_q      <= 1'b1;
			done_q    <= 1'b0;
			pc_q      <= '0;
			len0_q    <= '0;
			created_q <= CW'(1);
			scan_q    <= '0;
			cnt_q     <= '0;
		end else begin
			state_q   <= state_d;
			done_q    <= fin;
			pc_q      <= pc_d;
			len0_q    <= len0_d;
			created_q <= created_d;
			scan_q    <= scan_d;
			cnt_q     <= cnt_d;
			if (fin) begin
				stop_q <= fin_status;
			end
			if (cfg_valid && cfg_ready) begin
				oe_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			item_q <= item;
		end
		instr_q   <= instr_d;
		rb_q      <= rb_d;
		rc_q      <= rc_d;
		acc_id_q  <= acc_id_d;
		acc_idx_q <= acc_idx_d;
		slot_q    <= slot_d;
		size_q    <= size_d;
		if (fin) begin
			result_q <= '{status: fin_status, out_valid: fin_ov,
				out_char: fin_oc, input_used: fin_iu};
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

`include "universal_machine_core_assert.svh"

	`UMC_ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)
	`UMC_ASSERT_NEXT(a_stop_sticky, clk, arst_n, stop_q != ST_RUNNING, $stable(stop_q))
	`UMC_ASSERT_NOW(a_status_match, clk, arst_n, done_q, result_q.status == stop_q)
	`UMC_ASSERT_NOW(a_len0_bound, clk, arst_n, 1'b1, len0_q <= LW'(ARRAY_WORDS))

endmodule
`default_nettype wire

FILE: test/universal_machine_core_tb.sv
// Self-checking testbench for universal_machine_core: a command driver and a result monitor.
// A shadow machine plans safe programs, predicts every result, and the monitor checks them in order.
// Depends on umc_pkg and the universal_machine_core RTL.
`timescale 1ns / 1ps
module universal_machine_core_tb;
	import umc_pkg::*;

	localparam int SLOTS = 64;
	localparam int WORDS = 1024;
	localparam int ITEM_GOAL = 1850;
	localparam int NUM_PHASES = 6;
	localparam longint CYCLE_LIMIT = 20_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic done;
	out_item_t result;

	universal_machine_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	// Shadow machine state
	logic [31:0] regs [8];
	bit [31:0] mem [SLOTS * WORDS];
	int unsigned pc;
	int unsigned len [SLOTS];
	bit act [SLOTS];
	int unsigned made;
	logic [3:0] halt_code;
	bit out_en;

	in_item_t pend_q [$];
	out_item_t expected_q [$];
	int items_sent = 0;
	int fails = 0;
	int gap_left = 0;
	bit calm = 1'b0;
	longint cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [3:0] access_err(logic [31:0] id, logic [31:0] idx);
		if (id >= made || id >= SLOTS)
			return ST_BAD_ID;
		if (!act[id])
			return ST_INACTIVE;
		if (idx >= len[id])
			return ST_INDEX_RANGE;
		return ST_RUNNING;
	endfunction

	// Execute one instruction word; with commit low only the outcome is computed
	function automatic logic [3:0] run_word(logic [31:0] w, logic [7:0] ch, bit commit,
			inout out_item_t r);
		logic [3:0] opc;
		logic [2:0] a, b, c;
		logic [3:0] e;
		logic [31:0] id;
		int unsigned slot;
		opc = w[31:28];
		a = w[8:6];
		b = w[5:3];
		c = w[2:0];
		case (opc)
			OP_CMOV: begin
				if (commit && regs[c] != 0)
					regs[a] = regs[b];
			end
			OP_INDEX: begin
				e = access_err(regs[b], regs[c]);
				if (e != ST_RUNNING)
					return e;
				if (commit)
					regs[a] = mem[regs[b] * WORDS + regs[c]];
			end
			OP_AMEND: begin
				e = access_err(regs[a], regs[b]);
				if (e != ST_RUNNING)
					return e;
				if (commit)
					mem[regs[a] * WORDS + regs[b]] = regs[c];
			end
			OP_ADD: if (commit) regs[a] = regs[b] + regs[c];
			OP_MUL: if (commit) regs[a] = regs[b] * regs[c];
			OP_DIV: begin
				if (regs[c] == 0)
					return ST_DIV_ZERO;
				if (commit)
					regs[a] = regs[b] / regs[c];
			end
			OP_NAND: if (commit) regs[a] = ~(regs[b] & regs[c]);
			OP_HALT: return ST_HALTED;
			OP_ALLOC: begin
				if (regs[c] > WORDS)
					return ST_NO_RESOURCES;
				slot = 0;
				for (int i = 1; i < made && i < SLOTS; i++) begin
					if (!act[i]) begin
						slot = i;
						break;
					end
				end
				if (slot == 0) begin
					if (made >= SLOTS)
						return ST_NO_RESOURCES;
					slot = made;
					if (commit)
						made++;
				end
				if (commit) begin
					for (int i = 0; i < WORDS; i++)
						mem[slot * WORDS + i] = '0;
					len[slot] = regs[c];
					act[slot] = 1'b1;
					regs[b] = slot;
				end
			end
			OP_ABANDON: begin
				if (regs[c] == 0)
					return ST_BAD_ID;
				if (commit && regs[c] < SLOTS && act[regs[c]]) begin
					act[regs[c]] = 1'b0;
					len[regs[c]] = 0;
				end
			end
			OP_OUTPUT: begin
				if (out_en) begin
					r.out_valid = 1'b1;
					r.out_char = regs[c][7:0];
				end
			end
			OP_INPUT: begin
				if (commit)
					regs[c] = {24'b0, ch};
				r.input_used = 1'b1;
			end
			OP_LOADPROG: begin
				id = regs[b];
				if (id == 0) begin
					if (regs[c] >= len[0])
						return ST_PC_RANGE;
					if (commit)
						pc = regs[c];
				end else begin
					if (id >= made || id >= SLOTS || !act[id])
						return ST_INACTIVE;
					if (regs[c] >= len[id])
						return ST_INDEX_RANGE;
					if (commit) begin
						for (int i = 0; i < WORDS; i++)
							mem[i] = mem[id * WORDS + i];
						len[0] = len[id];
						pc = regs[c];
					end
				end
			end
			OP_ORTHO: if (commit) regs[w[27:25]] = {7'b0, w[24:0]};
			default: return ST_BAD_OPCODE;
		endcase
		return ST_RUNNING;
	endfunction

	// Advance the shadow machine by one item and return the result it must produce
	function automatic out_item_t machine_result(in_item_t it);
		out_item_t r;
		logic [31:0] w;
		r = '0;
		if (halt_code == ST_RUNNING) begin
			if (!it.func) begin
				if (len[0] >= WORDS)
					halt_code = ST_TOO_LONG;
				else begin
					mem[len[0]] = it.load_word;
					len[0]++;
				end
			end else if (len[0] == 0)
				halt_code = ST_NO_PROGRAM;
			else if (pc >= len[0])
				halt_code = ST_PC_RANGE;
			else begin
				w = mem[pc];
				pc++;
				halt_code = run_word(w, it.in_char, 1'b1, r);
			end
		end
		if (halt_code != ST_RUNNING)
			r = '0;
		r.status = halt_code;
		return r;
	endfunction

	task automatic queue_item(bit fn, logic [31:0] w, logic [7:0] ch);
		in_item_t it;
		it.func = fn;
		it.load_word = w;
		it.in_char = ch;
		expected_q.push_back(machine_result(it));
		pend_q.push_back(it);
		items_sent++;
	endtask

	// Append a word, execute it, then run any pure words that a jump left ahead of pc
	task automatic exec_word(logic [31:0] w, logic [7:0] ch);
		queue_item(1'b0, w, 8'($urandom));
		queue_item(1'b1, 32'($urandom), ch);
		while (halt_code == ST_RUNNING && pc < len[0])
			queue_item(1'b1, 32'($urandom), 8'($urandom));
	endtask

	function automatic logic [31:0] ins(opcode_t op, logic [2:0] a, logic [2:0] b,
			logic [2:0] c);
		logic [18:0] junk;
		junk = 19'($urandom);
		return {op, junk, a, b, c};
	endfunction

	function automatic logic [31:0] imm(logic [2:0] rd, logic [24:0] v);
		return {OP_ORTHO, rd, v};
	endfunction

	function automatic bit pure_word(logic [31:0] w);
		return w[31:28] == OP_CMOV || w[31:28] == OP_ADD || w[31:28] == OP_MUL ||
			w[31:28] == OP_NAND || w[31:28] == OP_ORTHO;
	endfunction

	// Execute only when the word cannot stop the machine; jumps only on request
	task automatic try_word(logic [31:0] w, bit allow_jump);
		out_item_t scratch;
		logic [7:0] ch;
		ch = 8'($urandom);
		scratch = '0;
		if (w[31:28] == OP_LOADPROG && !allow_jump)
			return;
		if (run_word(w, ch, 1'b0, scratch) == ST_RUNNING)
			exec_word(w, ch);
	endtask

	function automatic int copy_source();
		for (int i = 1; i < made && i < SLOTS; i++) begin
			if (act[i] && len[i] > 0 && pure_word(mem[i * WORDS + len[i] - 1]))
				return i;
		end
		return -1;
	endfunction

	function automatic int filled_slot();
		int base;
		base = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			if ((base + k) % SLOTS < made && act[(base + k) % SLOTS] &&
					len[(base + k) % SLOTS] > 0)
				return (base + k) % SLOTS;
		end
		return -1;
	endfunction

	function automatic logic [31:0] random_word();
		logic [3:0] op;
		if ($urandom_range(0, 99) < 30) begin
			if ($urandom_range(0, 9) < 6)
				return imm(3'($urandom), 25'($urandom_range(0, 12)));
			return imm(3'($urandom), 25'($urandom));
		end
		op = 4'($urandom_range(0, 13));
		return {op, 28'($urandom)};
	endfunction

	// Replace the program with a copied array whose last word is pure
	task automatic copy_program();
		int src;
		src = copy_source();
		if (src < 0) begin
			try_word(imm(3, 1), 1'b0);
			try_word(ins(OP_ALLOC, 0, 5, 3), 1'b0);
			src = copy_source();
		end
		if (src < 0)
			return;
		try_word(imm(5, 25'(src)), 1'b0);
		try_word(imm(4, 25'(len[src] - 1)), 1'b0);
		try_word(ins(OP_LOADPROG, 3'($urandom), 5, 4), 1'b1);
	endtask

	task automatic random_instruction();
		int k;
		int s;
		k = $urandom_range(0, 99);
		if (len[0] > 800 || k < 3)
			copy_program();
		else if (k < 9) begin
			if ($urandom_range(0, 19) == 0)
				try_word(imm(3, 25'($urandom_range(0, WORDS))), 1'b0);
			else
				try_word(imm(3, 25'($urandom_range(0, 4))), 1'b0);
			try_word(ins(OP_ALLOC, 3'($urandom), 3'($urandom_range(0, 7)), 3), 1'b0);
		end else if (k < 19) begin
			s = filled_slot();
			if (s < 0)
				return;
			try_word(imm(1, 25'(s)), 1'b0);
			try_word(imm(2, 25'($urandom_range(0, len[s] - 1))), 1'b0);
			if ($urandom_range(0, 1))
				try_word(ins(OP_AMEND, 1, 2, 3'($urandom)), 1'b0);
			else
				try_word(ins(OP_INDEX, 3'($urandom), 1, 2), 1'b0);
		end else if (k < 23) begin
			try_word(imm(1, 25'($urandom_range(1, made + 1))), 1'b0);
			try_word(ins(OP_ABANDON, 3'($urandom), 3'($urandom), 1), 1'b0);
		end else if (k < 31)
			try_word(ins($urandom_range(0, 1) ? OP_OUTPUT : OP_INPUT,
				3'($urandom), 3'($urandom), 3'($urandom)), 1'b0);
		else
			try_word(random_word(), 1'b0);
	endtask

	task automatic wait_idle();
		while (pend_q.size() > 0 || expected_q.size() > 0 || start)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_enable(bit v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		out_en = v;
	endtask

	// Stop the machine with a randomly chosen halt or error, then show that the stop is sticky
	task automatic stop_machine();
		case ($urandom_range(0, 7))
			0: exec_word(ins(OP_HALT, 3'($urandom), 3'($urandom), 3'($urandom)), 8'($urandom));
			1: exec_word({4'($urandom_range(14, 15)), 28'($urandom)}, 8'($urandom));
			2: begin
				exec_word(imm(4, 0), 8'($urandom));
				exec_word(ins(OP_DIV, 1, 2, 4), 8'($urandom));
			end
			3: begin
				exec_word(imm(4, 25'h1FFFFFF), 8'($urandom));
				exec_word(ins(OP_INDEX, 1, 4, 4), 8'($urandom));
			end
			4: begin
				exec_word(imm(4, 0), 8'($urandom));
				exec_word(ins(OP_ABANDON, 1, 2, 4), 8'($urandom));
			end
			5: begin
				exec_word(imm(1, 0), 8'($urandom));
				exec_word(imm(4, 25'h1FFFFFF), 8'($urandom));
				exec_word(ins(OP_LOADPROG, 0, 1, 4), 8'($urandom));
			end
			6: begin
				exec_word(imm(4, 25'h1FFFFFF), 8'($urandom));
				exec_word(ins(OP_ALLOC, 0, 2, 4), 8'($urandom));
			end
			default: begin
				exec_word(imm(1, 25'h1FFFFFF), 8'($urandom));
				exec_word(ins(OP_LOADPROG, 0, 1, 1), 8'($urandom));
			end
		endcase
		for (int i = 0; halt_code == ST_RUNNING && i < 50; i++)
			exec_word({4'($urandom_range(0, 15)), 28'($urandom)}, 8'($urandom));
		for (int i = 0; i < 8; i++)
			queue_item(1'($urandom), 32'($urandom), 8'($urandom));
	endtask

	// Directed program: extremes, every operation but halt, jumps and a program copy
	task automatic directed_program();
		int unsigned target;
		exec_word(imm(0, 25'h1FFFFFF), 8'h00);
		exec_word(imm(1, 0), 8'h00);
		exec_word(imm(4, 7), 8'h00);
		exec_word(ins(OP_ADD, 2, 0, 0), 8'h00);
		exec_word(ins(OP_MUL, 3, 0, 0), 8'h00);
		exec_word(ins(OP_NAND, 2, 3, 0), 8'h00);
		exec_word(ins(OP_DIV, 3, 0, 4), 8'h00);
		exec_word(ins(OP_CMOV, 5, 0, 4), 8'h00);
		exec_word(ins(OP_CMOV, 6, 0, 1), 8'h00);
		exec_word(ins(OP_INPUT, 0, 0, 6), 8'hFF);
		exec_word(ins(OP_OUTPUT, 0, 0, 6), 8'h00);
		exec_word(ins(OP_INPUT, 0, 0, 6), 8'h00);
		exec_word(ins(OP_OUTPUT, 0, 0, 6), 8'h00);
		exec_word(imm(4, 2), 8'h00);
		exec_word(ins(OP_ALLOC, 0, 5, 4), 8'h00);
		exec_word(ins(OP_AMEND, 5, 1, 0), 8'h00);
		exec_word(ins(OP_INDEX, 6, 5, 1), 8'h00);
		exec_word(ins(OP_ALLOC, 0, 7, 4), 8'h00);
		exec_word(ins(OP_ABANDON, 0, 0, 7), 8'h00);
		exec_word(ins(OP_ABANDON, 0, 0, 0), 8'h00);
		// Jump forward within the program over a halt
		target = len[0] + 3;
		exec_word(imm(7, 25'(target)), 8'h00);
		queue_item(1'b0, ins(OP_LOADPROG, 0, 1, 7), 8'($urandom));
		queue_item(1'b0, ins(OP_HALT, 0, 0, 0), 8'($urandom));
		exec_word(32'h0, 8'h00);
		// Copy a one-word array into the program and resume at its end
		exec_word(imm(4, 1), 8'h00);
		exec_word(ins(OP_ALLOC, 0, 5, 4), 8'h00);
		exec_word(ins(OP_LOADPROG, 0, 5, 1), 8'h00);
	endtask

	// Feed pending items into the block; insert random idle bursts between transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (!(start && busy)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pend_q.size() > 0) begin
				item <= pend_q.pop_front();
				start <= 1'b1;
				if (!calm && $urandom_range(0, 6) == 0)
					gap_left <= $urandom_range(1, 18);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Check each result strobe against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result status %0d", result.status);
				fails++;
			end else begin
				want = expected_q.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fails++;
				end
				if (result.out_valid !== want.out_valid) begin
					$error("out_valid: expected %0d, got %0d", want.out_valid,
						result.out_valid);
					fails++;
				end
				if (result.out_char !== want.out_char) begin
					$error("out_char: expected %0h, got %0h", want.out_char, result.out_char);
					fails++;
				end
				if (result.input_used !== want.input_used) begin
					$error("input_used: expected %0d, got %0d", want.input_used,
						result.input_used);
					fails++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** universal_machine_core: FAILED **");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++)
			regs[i] = '0;
		for (int i = 0; i < SLOTS; i++) begin
			len[i] = 0;
			act[i] = (i == 0);
		end
		pc = 0;
		made = 1;
		halt_code = ST_RUNNING;
		out_en = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_enable(1'b1);
		directed_program();

		// Random programs in phases, each under its own output setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			if (ph == 0)
				write_enable(1'b0);
			else if (ph == 1)
				write_enable(1'b1);
			else
				write_enable(1'($urandom));
			calm = (ph == NUM_PHASES - 1);
			while (halt_code == ST_RUNNING && pc == len[0] && len[0] < WORDS - 8 &&
					items_sent < (ITEM_GOAL * (ph + 1)) / NUM_PHASES)
				random_instruction();
		end
		stop_machine();

		wait_idle();
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("** universal_machine_core: PASSED **");
		else
			$display("** universal_machine_core: FAILED **");
		$finish;
	end

endmodule
